// File: design/pf_pkg.sv
// Shared types and constants for the prime factorizer.
// Used by the controller, the datapath and the top level; depends on nothing.
package pf_pkg;

  localparam int MAX_RESULTS = 30;
  localparam int CNT_W       = 5;
  localparam int FACTOR_W    = 31;

  typedef enum logic [1:0] {
    SRC_TWO = 2'd0,
    SRC_DIV = 2'd1,
    SRC_REM = 2'd2
  } factor_src_e;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LOAD  = 8'b0000_0010,
    ST_TWOS  = 8'b0000_0100,
    ST_TRIAL = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_REDIV = 8'b0010_0000,
    ST_TAIL  = 8'b0100_0000,
    ST_FLUSH = 8'b1000_0000
  } ctrl_state_e;

  typedef struct packed {
    logic        load;
    logic        take;
    factor_src_e src;
    logic        div_start;
    logic        next_d;
    logic        flush;
  } pf_cmd_t;

  typedef struct packed {
    logic n_small;
    logic n_even;
    logic n_is_one;
    logic sq_gt_n;
    logic div_done;
    logic rem_zero;
    logic at_limit;
  } pf_status_t;

endpackage

// File: design/prime_factorizer_top.sv
// Factors of 2 are taken first, then trial division by odd divisors on the shared
// one-bit-a-step divider, up to about 23000 odd divisors for a 32-bit prime near
// the top of the range.
// One item at a time; start is taken only while busy is low.
// Each result beat is on the ports for one cycle, marked by strobe_o.
// Reset is asynchronous and active low and returns the block to idle.
module prime_factorizer_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         strobe_o,
  output logic [30:0]                  factor_o,
  output logic                         last_o
);

  import pf_pkg::*;

  pf_cmd_t    cmd;
  pf_status_t status;

  pf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .status_i(status),
    .cmd_o   (cmd)
  );

  pf_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (value_i),
    .cmd_i   (cmd),
    .status_o(status),
    .strobe_o(strobe_o),
    .factor_o(factor_o),
    .last_o  (last_o)
  );

endmodule

// File: design/pf_div.sv
// Restoring divider that yields one quotient bit per cycle.
// Stand-alone unit used by the datapath; depends on nothing.
module pf_div #(
  parameter int DW = 32,
  parameter int VW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o,
  output logic [VW-1:0] rem_o
);

  localparam int CW = $clog2(DW);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] div_q, div_d;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (run_q) begin
      rem_d = ge ? diff[VW-1:0] : shifted[VW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: design/pf_ctrl.sv
// Controller state machine of the prime factorizer.
// Depends on pf_pkg; drives the datapath by command and reads its status.
module pf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pf_pkg::pf_status_t status_i,
  output pf_pkg::pf_cmd_t    cmd_o
);

  import pf_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.src = SRC_TWO;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = status_i.n_small ? ST_IDLE : ST_TWOS;
      end
      ST_TWOS: begin
        if (status_i.n_even) begin
          cmd_o.take = 1'b1;
          cmd_o.src  = SRC_TWO;
          if (status_i.at_limit) begin
            state_d = ST_FLUSH;
          end
        end else begin
          state_d = ST_TRIAL;
        end
      end
      ST_TRIAL: begin
        if (status_i.sq_gt_n) begin
          state_d = ST_TAIL;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            cmd_o.take = 1'b1;
            cmd_o.src  = SRC_DIV;
            state_d    = status_i.at_limit ? ST_FLUSH : ST_REDIV;
          end else begin
            cmd_o.next_d = 1'b1;
            state_d      = ST_TRIAL;
          end
        end
      end
      ST_REDIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_TAIL: begin
        if (!status_i.n_is_one) begin
          cmd_o.take = 1'b1;
          cmd_o.src  = SRC_REM;
        end
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// File: design/pf_datapath.sv
// Datapath of the prime factorizer: remaining value, trial divisor and its
// square, the held-back factor and the result registers. Depends on pf_pkg, pf_div.
module pf_datapath #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic signed [DATA_WIDTH-1:0]   value_i,
  input  pf_pkg::pf_cmd_t                cmd_i,
  output pf_pkg::pf_status_t             status_o,
  output logic                           strobe_o,
  output logic [pf_pkg::FACTOR_W-1:0]    factor_o,
  output logic                           last_o
);

  import pf_pkg::*;

  localparam int VW = DATA_WIDTH / 2 + 1;
  localparam int SW = 2 * VW;

  logic [DATA_WIDTH-1:0] n_q, n_d;
  logic [VW-1:0]         d_q, d_d;
  logic [SW-1:0]         sq_q, sq_d;
  logic [FACTOR_W-1:0]   pend_q, pend_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  strobe_q, strobe_d;
  logic [FACTOR_W-1:0]   factor_q, factor_d;
  logic                  last_q, last_d;

  logic                  div_done;
  logic [DATA_WIDTH-1:0] quo;
  logic [VW-1:0]         rem;
  logic [FACTOR_W-1:0]   new_factor;
  logic [VW+FACTOR_W-1:0]         d_ext;
  logic [DATA_WIDTH+FACTOR_W-1:0] n_ext;

  pf_div #(
    .DW(DATA_WIDTH),
    .VW(VW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(n_q),
    .divisor_i (d_q),
    .done_o    (div_done),
    .quo_o     (quo),
    .rem_o     (rem)
  );

  assign d_ext = (VW + FACTOR_W)'(d_q);
  assign n_ext = (DATA_WIDTH + FACTOR_W)'(n_q);

  always_comb begin
    case (cmd_i.src)
      SRC_TWO: new_factor = FACTOR_W'(2);
      SRC_DIV: new_factor = d_ext[FACTOR_W-1:0];
      SRC_REM: new_factor = n_ext[FACTOR_W-1:0];
      default: new_factor = FACTOR_W'(2);
    endcase
  end

  always_comb begin
    status_o.n_small  = n_q[DATA_WIDTH-1] || (n_q <= DATA_WIDTH'(1));
    status_o.n_even   = !n_q[0];
    status_o.n_is_one = (n_q == DATA_WIDTH'(1));
    status_o.sq_gt_n  = sq_q > SW'(n_q);
    status_o.div_done = div_done;
    status_o.rem_zero = (rem == '0);
    status_o.at_limit = (cnt_q == CNT_W'(MAX_RESULTS - 1));
  end

  always_comb begin
    n_d        = n_q;
    d_d        = d_q;
    sq_d       = sq_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    cnt_d      = cnt_q;
    strobe_d   = 1'b0;
    factor_d   = pend_q;
    last_d     = 1'b0;
    if (cmd_i.load) begin
      n_d        = value_i;
      d_d        = VW'(3);
      sq_d       = SW'(9);
      pend_vld_d = 1'b0;
      cnt_d      = '0;
    end
    if (cmd_i.take) begin
      strobe_d   = pend_vld_q;
      pend_d     = new_factor;
      pend_vld_d = 1'b1;
      cnt_d      = cnt_q + CNT_W'(1);
      case (cmd_i.src)
        SRC_TWO: n_d = n_q >> 1;
        SRC_DIV: n_d = quo;
        default: n_d = n_q;
      endcase
    end
    if (cmd_i.next_d) begin
      d_d  = d_q + VW'(2);
      sq_d = sq_q + SW'({d_q, 2'b00}) + SW'(4);
    end
    if (cmd_i.flush) begin
      strobe_d   = pend_vld_q;
      last_d     = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      strobe_q   <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      cnt_q      <= cnt_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    d_q      <= d_d;
    sq_q     <= sq_d;
    pend_q   <= pend_d;
    factor_q <= factor_d;
    last_q   <= last_d;
  end

  assign strobe_o = strobe_q;
  assign factor_o = factor_q;
  assign last_o   = last_q;

endmodule
